// ===== sv/rre_pkg.sv =====
// rre_pkg: widths, constants and types shared by the range estimator files
// no dependencies
`timescale 1ns / 1ps
package rre_pkg;
    localparam int NODE_COUNT = 3;
    localparam int CW         = 24;
    localparam int NODE_W     = 2;
    localparam int CFG_COUNT  = 3;
    localparam int CFG_W      = 24;
    localparam int CFG_IDX_W  = $clog2(CFG_COUNT);
    localparam int SQ_W       = 2 * CW;
    localparam int TOT_W      = CW + 1;
    localparam int TOT_IN_W   = 2 * TOT_W;
    localparam int SCALE_W    = 20;
    localparam logic [SCALE_W-1:0] SCALE = 20'd1000000;
    localparam int DIVD_W     = CFG_W + SCALE_W;
    localparam int DIST_W     = 23;
    localparam int CB_SHIFT   = 24;
    localparam int CN_W       = 3 * DIST_W;
    localparam int CRW        = 2 * DIST_W + 4;
    localparam int R2W        = 2 * DIST_W;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
    localparam int L_AX       = CW + 3;
    localparam int L_TOT      = TOT_W + 2;
    localparam int RNG_LAT    = 1 + DIVD_W + DIST_W;
    localparam int LAT        = L_AX + L_TOT + RNG_LAT + 1;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [CW-1:0]     mag_x;
        logic [CW-1:0]     mag_y;
        logic [CW-1:0]     mag_z;
    } t_mags;
endpackage

// ===== sv/rre_axis_mag.sv =====
// rre_axis_mag: pipelined floored magnitude of one complex bin value
// depends on rre_pkg
`timescale 1ns / 1ps
module rre_axis_mag import rre_pkg::*; (
    input  logic                 i_clk,
    input  logic signed [CW-1:0] i_re,
    input  logic signed [CW-1:0] i_im,
    output logic [CW-1:0]        o_mag
);
    localparam int RW = CW + 2;

    logic [CW-1:0]   r_abs_re, r_abs_im;
    logic [SQ_W-1:0] r_sq_re, r_sq_im;
    logic [SQ_W-1:0] r_sum;
    logic [SQ_W-1:0] r_sn  [1:CW];
    logic [RW-1:0]   r_rem [1:CW];
    logic [CW-1:0]   r_rt  [1:CW];

    always_ff @(posedge i_clk) begin
        r_abs_re <= i_re[CW-1] ? (~i_re + 1'b1) : i_re;
        r_abs_im <= i_im[CW-1] ? (~i_im + 1'b1) : i_im;
        r_sq_re  <= r_abs_re * r_abs_re;
        r_sq_im  <= r_abs_im * r_abs_im;
        r_sum    <= r_sq_re + r_sq_im;
    end

    for (genvar k = 1; k <= CW; k++) begin : g_root
        logic [SQ_W-1:0] p_sn;
        logic [RW-1:0]   p_rem, remsh, trial;
        logic [CW-1:0]   p_rt;
        logic            ge;
        if (k == 1) begin : g_first
            assign p_sn  = r_sum;
            assign p_rem = '0;
            assign p_rt  = '0;
        end else begin : g_next
            assign p_sn  = r_sn[k-1];
            assign p_rem = r_rem[k-1];
            assign p_rt  = r_rt[k-1];
        end
        assign remsh = {p_rem[RW-3:0], p_sn[SQ_W-1 -: 2]};
        assign trial = {p_rt, 2'b01};
        assign ge    = remsh >= trial;
        always_ff @(posedge i_clk) begin
            r_sn[k]  <= {p_sn[SQ_W-3:0], 2'b00};
            r_rem[k] <= ge ? (remsh - trial) : remsh;
            r_rt[k]  <= {p_rt[CW-2:0], ge};
        end
    end

    assign o_mag = r_rt[CW];
endmodule

// ===== sv/rre_range.sv =====
// rre_range: scaled constant divided by total magnitude, then Q15.8 cube root
// depends on rre_pkg
`timescale 1ns / 1ps
module rre_range import rre_pkg::*; (
    input  logic              i_clk,
    input  logic [CFG_W-1:0]  i_cte,
    input  logic [TOT_W-1:0]  i_total,
    output logic [DIST_W-1:0] o_dist
);
    logic [DIVD_W-1:0] r_dvd0;
    logic [TOT_W-1:0]  r_dvs0;
    logic [DIVD_W-1:0] r_dvd [1:DIVD_W];
    logic [TOT_W-1:0]  r_dvs [1:DIVD_W];
    logic [TOT_W-1:0]  r_drm [1:DIVD_W];
    logic [DIVD_W-1:0] r_q   [1:DIVD_W];
    logic [CN_W-1:0]   r_cn  [1:DIST_W];
    logic [CRW-1:0]    r_crm [1:DIST_W];
    logic [DIST_W-1:0] r_cr  [1:DIST_W];
    logic [R2W-1:0]    r_cr2 [1:DIST_W];

    always_ff @(posedge i_clk) begin
        r_dvd0 <= DIVD_W'(i_cte) * DIVD_W'(SCALE);
        r_dvs0 <= i_total;
    end

    for (genvar k = 1; k <= DIVD_W; k++) begin : g_div
        logic [DIVD_W-1:0] p_dvd, p_q;
        logic [TOT_W-1:0]  p_dvs, p_rm;
        logic [TOT_W:0]    remsh;
        logic              ge;
        if (k == 1) begin : g_first
            assign p_dvd = r_dvd0;
            assign p_dvs = r_dvs0;
            assign p_rm  = '0;
            assign p_q   = '0;
        end else begin : g_next
            assign p_dvd = r_dvd[k-1];
            assign p_dvs = r_dvs[k-1];
            assign p_rm  = r_drm[k-1];
            assign p_q   = r_q[k-1];
        end
        assign remsh = {p_rm, p_dvd[DIVD_W-1]};
        assign ge    = remsh >= {1'b0, p_dvs};
        always_ff @(posedge i_clk) begin
            r_dvd[k] <= {p_dvd[DIVD_W-2:0], 1'b0};
            r_dvs[k] <= p_dvs;
            r_drm[k] <= ge ? TOT_W'(remsh - {1'b0, p_dvs}) : TOT_W'(remsh);
            r_q[k]   <= {p_q[DIVD_W-2:0], ge};
        end
    end

    for (genvar k = 1; k <= DIST_W; k++) begin : g_cbrt
        logic [CN_W-1:0]   p_cn;
        logic [CRW-1:0]    p_rm, remsh, dd;
        logic [DIST_W-1:0] p_r;
        logic [R2W-1:0]    p_r2;
        logic              ge;
        if (k == 1) begin : g_first
            assign p_cn = CN_W'({r_q[DIVD_W], {CB_SHIFT{1'b0}}});
            assign p_rm = '0;
            assign p_r  = '0;
            assign p_r2 = '0;
        end else begin : g_next
            assign p_cn = r_cn[k-1];
            assign p_rm = r_crm[k-1];
            assign p_r  = r_cr[k-1];
            assign p_r2 = r_cr2[k-1];
        end
        assign remsh = {p_rm[CRW-4:0], p_cn[CN_W-1 -: 3]};
        assign dd    = CRW'({p_r2, 3'b000}) + CRW'({p_r2, 2'b00})
                     + CRW'({p_r, 2'b00}) + CRW'({p_r, 1'b0}) + CRW'(1);
        assign ge    = remsh >= dd;
        always_ff @(posedge i_clk) begin
            r_cn[k]  <= {p_cn[CN_W-4:0], 3'b000};
            r_crm[k] <= ge ? (remsh - dd) : remsh;
            r_cr[k]  <= {p_r[DIST_W-2:0], ge};
            r_cr2[k] <= ge ? ({p_r2[R2W-3:0], 2'b00} + R2W'({p_r, 2'b00}) + R2W'(1))
                           : {p_r2[R2W-3:0], 2'b00};
        end
    end

    assign o_dist = r_cr[DIST_W];
endmodule

// ===== sv/magnetic_rss_range_estimator_core.sv =====
// magnetic_rss_range_estimator_core: top level of the rss range estimator
// depends on rre_pkg, rre_axis_mag, rre_range
`timescale 1ns / 1ps
// Takes one bin word per clock and never asserts busy. Each word gives one
// result strobe, in input order. The pipeline holds bit-serial stages: 24
// for each axis root, 25 for the total root, 44 for the divider and 23 for
// the cube root, plus squaring, summing and output registers. Source
// constants are written through the config channel, which is always ready;
// write them only while no word is in flight.
module magnetic_rss_range_estimator_core import rre_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [NODE_W-1:0]    i_node_index,
    input  logic signed [CW-1:0] i_re_x,
    input  logic signed [CW-1:0] i_im_x,
    input  logic signed [CW-1:0] i_re_y,
    input  logic signed [CW-1:0] i_im_y,
    input  logic signed [CW-1:0] i_re_z,
    input  logic signed [CW-1:0] i_im_z,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_result_valid,
    output logic [NODE_W-1:0]    o_node_out,
    output logic [CW-1:0]        o_mag_x,
    output logic [CW-1:0]        o_mag_y,
    output logic [CW-1:0]        o_mag_z,
    output logic [TOT_W-1:0]     o_total_magnitude,
    output logic [DIST_W-1:0]    o_distance,
    output logic                 o_zero_field
);
    logic              accept;
    logic [CFG_W-1:0]  r_cte [0:CFG_COUNT-1];
    logic              r_va [0:L_AX-1];
    logic [NODE_W-1:0] r_na [0:L_AX-1];
    logic              r_vb [0:L_TOT-1];
    t_mags             r_mb [0:L_TOT-1];
    logic              r_vc [0:RNG_LAT-1];
    t_mags             r_mc [0:RNG_LAT-1];
    logic [TOT_W-1:0]  r_tc [0:RNG_LAT-1];
    logic [CW-1:0]     mag_x, mag_y, mag_z;
    logic [SQ_W-1:0]   r_sqx, r_sqy, r_sqz;
    logic [TOT_IN_W-1:0] r_tsum;
    logic [TOT_IN_W-1:0] r_tn  [1:TOT_W];
    logic [TOT_W+1:0]    r_trm [1:TOT_W];
    logic [TOT_W-1:0]    r_trt [1:TOT_W];
    logic [CFG_W-1:0]  cte;
    logic [DIST_W-1:0] range_dist;
    logic              r_out_valid;
    t_mags             r_out_m;
    logic [TOT_W-1:0]  r_out_tot;
    logic [DIST_W-1:0] r_out_dist;
    logic              r_out_zero;

    assign busy        = 1'b0;
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_COUNT; i++) r_cte[i] <= '0;
        end else if (i_cfg_valid && o_cfg_ready && (32'(i_cfg_index) < CFG_COUNT)) begin
            r_cte[i_cfg_index] <= i_cfg_data;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < L_AX; i++) r_va[i] <= 1'b0;
            for (int i = 0; i < L_TOT; i++) r_vb[i] <= 1'b0;
            for (int i = 0; i < RNG_LAT; i++) r_vc[i] <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_va[0] <= accept;
            for (int i = 1; i < L_AX; i++) r_va[i] <= r_va[i-1];
            r_vb[0] <= r_va[L_AX-1];
            for (int i = 1; i < L_TOT; i++) r_vb[i] <= r_vb[i-1];
            r_vc[0] <= r_vb[L_TOT-1];
            for (int i = 1; i < RNG_LAT; i++) r_vc[i] <= r_vc[i-1];
            r_out_valid <= r_vc[RNG_LAT-1];
        end
    end

    // side data
    always_ff @(posedge i_clk) begin
        r_na[0] <= i_node_index;
        for (int i = 1; i < L_AX; i++) r_na[i] <= r_na[i-1];
        r_mb[0] <= '{node: r_na[L_AX-1], mag_x: mag_x, mag_y: mag_y, mag_z: mag_z};
        for (int i = 1; i < L_TOT; i++) r_mb[i] <= r_mb[i-1];
        r_mc[0] <= r_mb[L_TOT-1];
        r_tc[0] <= r_trt[TOT_W];
        for (int i = 1; i < RNG_LAT; i++) begin
            r_mc[i] <= r_mc[i-1];
            r_tc[i] <= r_tc[i-1];
        end
    end

    rre_axis_mag u_mag_x (.i_clk(i_clk), .i_re(i_re_x), .i_im(i_im_x), .o_mag(mag_x));
    rre_axis_mag u_mag_y (.i_clk(i_clk), .i_re(i_re_y), .i_im(i_im_y), .o_mag(mag_y));
    rre_axis_mag u_mag_z (.i_clk(i_clk), .i_re(i_re_z), .i_im(i_im_z), .o_mag(mag_z));

    always_ff @(posedge i_clk) begin
        r_sqx  <= mag_x * mag_x;
        r_sqy  <= mag_y * mag_y;
        r_sqz  <= mag_z * mag_z;
        r_tsum <= TOT_IN_W'(r_sqx) + TOT_IN_W'(r_sqy) + TOT_IN_W'(r_sqz);
    end

    // total magnitude root
    for (genvar k = 1; k <= TOT_W; k++) begin : g_troot
        logic [TOT_IN_W-1:0] p_tn;
        logic [TOT_W+1:0]    p_rm, remsh, trial;
        logic [TOT_W-1:0]    p_rt;
        logic                ge;
        if (k == 1) begin : g_first
            assign p_tn = r_tsum;
            assign p_rm = '0;
            assign p_rt = '0;
        end else begin : g_next
            assign p_tn = r_tn[k-1];
            assign p_rm = r_trm[k-1];
            assign p_rt = r_trt[k-1];
        end
        assign remsh = {p_rm[TOT_W-1:0], p_tn[TOT_IN_W-1 -: 2]};
        assign trial = {p_rt, 2'b01};
        assign ge    = remsh >= trial;
        always_ff @(posedge i_clk) begin
            r_tn[k]  <= {p_tn[TOT_IN_W-3:0], 2'b00};
            r_trm[k] <= ge ? (remsh - trial) : remsh;
            r_trt[k] <= {p_rt[TOT_W-2:0], ge};
        end
    end

    assign cte = (32'(r_mb[L_TOT-1].node) < NODE_COUNT && 32'(r_mb[L_TOT-1].node) < CFG_COUNT)
               ? r_cte[r_mb[L_TOT-1].node] : '0;

    rre_range u_range (
        .i_clk  (i_clk),
        .i_cte  (cte),
        .i_total(r_trt[TOT_W]),
        .o_dist (range_dist)
    );

    always_ff @(posedge i_clk) begin
        r_out_m    <= r_mc[RNG_LAT-1];
        r_out_tot  <= r_tc[RNG_LAT-1];
        r_out_zero <= (r_tc[RNG_LAT-1] == '0);
        r_out_dist <= (r_tc[RNG_LAT-1] == '0) ? DIST_MAX : range_dist;
    end

    assign o_result_valid    = r_out_valid;
    assign o_node_out        = r_out_m.node;
    assign o_mag_x           = r_out_m.mag_x;
    assign o_mag_y           = r_out_m.mag_y;
    assign o_mag_z           = r_out_m.mag_z;
    assign o_total_magnitude = r_out_tot;
    assign o_distance        = r_out_dist;
    assign o_zero_field      = r_out_zero;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LAT o_result_valid)
        else $error("result strobe missing after fixed latency");

    a_zero_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_zero_field |-> o_distance == DIST_MAX && o_total_magnitude == '0)
        else $error("zero field without saturated distance");

    a_total_ge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> 32'(o_total_magnitude) >= 32'(o_mag_x)
                        && 32'(o_total_magnitude) >= 32'(o_mag_y)
                        && 32'(o_total_magnitude) >= 32'(o_mag_z))
        else $error("total magnitude below an axis magnitude");
endmodule
